/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

/* hdl/swmm_pkg.sv */
// ---------------------------------------------------------------------------
// swmm_pkg
// Types and constants shared by the sliding window min/max block.
// ---------------------------------------------------------------------------
package swmm_pkg;

	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd3;

	typedef enum logic {
		QUEUE_MAX,
		QUEUE_MIN
	} queue_kind_t;

	typedef struct packed {
		logic       push;
		logic       clear;
		logic [1:0] shift;
	} cell_ctrl_t;

endpackage

/* hdl/swmm_ifs.sv */
// ---------------------------------------------------------------------------
// swmm channel interfaces
// Valid/ready channels for samples, results and the window size register.
// ---------------------------------------------------------------------------
interface swmm_sample_if #(
	parameter int SAMPLE_WIDTH = 32
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_value;
	logic                           sequence_end;

	modport source (output valid, sample_value, sequence_end, input ready);
	modport sink   (input valid, sample_value, sequence_end, output ready);
endinterface

interface swmm_result_if #(
	parameter int SAMPLE_WIDTH = 32
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] window_max;
	logic signed [SAMPLE_WIDTH-1:0] window_min;
	logic                           final_result;

	modport source (output valid, window_max, window_min, final_result, input ready);
	modport sink   (input valid, window_max, window_min, final_result, output ready);
endinterface

interface swmm_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [swmm_pkg::CFG_W-1:0]  window_size;

	modport source (output valid, window_size, input ready);
	modport sink   (input valid, window_size, output ready);
endinterface

/* hdl/sliding_window_min_max_top.sv */
// ---------------------------------------------------------------------------
// sliding_window_min_max_top
// Running maximum and minimum over a sliding window of signed samples.
// ---------------------------------------------------------------------------
// Takes one sample per clock and, once window_size samples of a sequence have
// arrived, gives one beat per sample carrying the max and min of the last
// window_size samples; each result is written into the output buffer as its sample is taken.
// The window is held in two rows of MAX_WINDOW cells (one decreasing queue for
// the max, one increasing for the min), all updated in the same cycle, so the
// rate is one sample per clock, set by the compare in each cell plus the front
// retirement check. A two-beat output buffer lets samples flow while a result
// waits; input stalls only when both slots are held. sequence_end marks the
// last sample and clears the window state after it. window_size of 0 acts as
// 1 and values above MAX_WINDOW act as MAX_WINDOW; change it only when idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_window_min_max_top #(
	parameter int MAX_WINDOW   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	swmm_sample_if.sink samples,
	swmm_result_if.source results,
	swmm_cfg_if.sink    cfg
);

	localparam int CFG_W   = swmm_pkg::CFG_W;
	localparam int POS_W   = (2 * MAX_WINDOW > 1) ? $clog2(2 * MAX_WINDOW) : 1;
	localparam int FILL_W  = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W   = (FILL_W > CFG_W) ? FILL_W : CFG_W;
	localparam int POS_TOP = 2 * MAX_WINDOW - 1;
	localparam int RES_W   = 2 * SAMPLE_WIDTH + 1;

	logic [CFG_W-1:0]  win_q;
	logic [FILL_W-1:0] filled_q;
	logic [POS_W-1:0]  newest_q;
	logic [POS_W-1:0]  oldest_q;

	logic [FILL_W-1:0] eff_w;
	logic [FILL_W-1:0] fill_next;
	logic              accept;
	logic              fire;
	logic              last;
	logic              room;
	logic              max_retire;
	logic              min_retire;

	logic                           max_fv;
	logic signed [SAMPLE_WIDTH-1:0] max_fd;
	logic [POS_W-1:0]               max_fp;
	logic                           min_fv;
	logic signed [SAMPLE_WIDTH-1:0] min_fd;
	logic [POS_W-1:0]               min_fp;
	logic [RES_W-1:0]               res_data;

	assign cfg.ready     = 1'b1;
	assign samples.ready = room;
	assign accept        = samples.valid && room;
	assign last          = samples.sequence_end;

	always_comb begin
		if (win_q == '0) begin
			eff_w = FILL_W'(1);
		end else if (CMP_W'(win_q) > CMP_W'(MAX_WINDOW)) begin
			eff_w = FILL_W'(MAX_WINDOW);
		end else begin
			eff_w = FILL_W'(win_q);
		end
		fill_next = (filled_q < eff_w) ? filled_q + FILL_W'(1) : filled_q;
	end

	assign fire       = accept && (fill_next >= eff_w);
	assign max_retire = fire && max_fv && (max_fp == oldest_q);
	assign min_retire = fire && min_fv && (min_fp == oldest_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= swmm_pkg::WINDOW_RESET;
			filled_q <= '0;
			newest_q <= '0;
			oldest_q <= '0;
		end else begin
			if (cfg.valid) begin
				win_q <= cfg.window_size;
			end
			if (accept && last) begin
				filled_q <= '0;
				newest_q <= '0;
				oldest_q <= '0;
			end else if (accept) begin
				filled_q <= fill_next;
				newest_q <= (newest_q == POS_W'(POS_TOP)) ? '0 : newest_q + POS_W'(1);
				if (fire) begin
					oldest_q <= (oldest_q == POS_W'(POS_TOP)) ? '0 : oldest_q + POS_W'(1);
				end
			end
		end
	end

	swmm_queue #(
		.KIND (swmm_pkg::QUEUE_MAX),
		.N    (MAX_WINDOW),
		.SW   (SAMPLE_WIDTH),
		.PW   (POS_W)
	) u_max_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (accept),
		.clear       (accept && last),
		.retire      (max_retire),
		.sample      (samples.sample_value),
		.pos         (newest_q),
		.front_valid (max_fv),
		.front_value (max_fd),
		.front_pos   (max_fp)
	);

	swmm_queue #(
		.KIND (swmm_pkg::QUEUE_MIN),
		.N    (MAX_WINDOW),
		.SW   (SAMPLE_WIDTH),
		.PW   (POS_W)
	) u_min_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (accept),
		.clear       (accept && last),
		.retire      (min_retire),
		.sample      (samples.sample_value),
		.pos         (newest_q),
		.front_valid (min_fv),
		.front_value (min_fd),
		.front_pos   (min_fp)
	);

	swmm_outbuf #(
		.W (RES_W)
	) u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.push_data ({max_fd, min_fd, last}),
		.room      (room),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_data  (res_data)
	);

	assign results.window_max   = res_data[RES_W-1 -: SAMPLE_WIDTH];
	assign results.window_min   = res_data[SAMPLE_WIDTH -: SAMPLE_WIDTH];
	assign results.final_result = res_data[0];

	`ASSERT_PROP(a_end_clears, clk, arst_n, accept && last |=> !(|{filled_q, oldest_q, newest_q}))
	`ASSERT_PROP(a_fronts_valid, clk, arst_n, fire |-> max_fv && min_fv)

endmodule

/* hdl/swmm_cell.sv */
// ---------------------------------------------------------------------------
// swmm_cell
// One entry of a monotonic queue: compares against the new sample, reports
// whether it survives, and loads itself from its own or a neighbor's entry.
// ---------------------------------------------------------------------------
module swmm_cell #(
	parameter swmm_pkg::queue_kind_t KIND = swmm_pkg::QUEUE_MAX,
	parameter int SW = 32,
	parameter int PW = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swmm_pkg::cell_ctrl_t ctrl,
	input  logic signed [SW-1:0] sample,
	input  logic [PW-1:0]        pos,
	input  logic                 prev_kept,
	input  logic                 nxt1_valid,
	input  logic signed [SW-1:0] nxt1_value,
	input  logic [PW-1:0]        nxt1_pos,
	input  logic                 nxt2_valid,
	input  logic signed [SW-1:0] nxt2_value,
	input  logic [PW-1:0]        nxt2_pos,
	output logic                 kept,
	output logic                 a_valid,
	output logic signed [SW-1:0] a_value,
	output logic [PW-1:0]        a_pos,
	output logic                 cur_valid,
	output logic signed [SW-1:0] cur_value
);

	logic                 valid_q;
	logic signed [SW-1:0] value_q;
	logic [PW-1:0]        pos_q;
	logic                 dom;
	logic                 ins;
	logic                 sel_valid;
	logic signed [SW-1:0] sel_value;
	logic [PW-1:0]        sel_pos;

	always_comb begin
		if (KIND == swmm_pkg::QUEUE_MAX) begin
			dom = (value_q <= sample);
		end else begin
			dom = (value_q >= sample);
		end
		kept    = valid_q && !dom;
		ins     = !kept && prev_kept;
		a_valid = kept || ins;
		a_value = kept ? value_q : sample;
		a_pos   = kept ? pos_q : pos;
	end

	always_comb begin
		case (ctrl.shift)
			2'd0: begin
				sel_valid = a_valid;
				sel_value = a_value;
				sel_pos   = a_pos;
			end
			2'd1: begin
				sel_valid = nxt1_valid;
				sel_value = nxt1_value;
				sel_pos   = nxt1_pos;
			end
			default: begin
				sel_valid = nxt2_valid;
				sel_value = nxt2_value;
				sel_pos   = nxt2_pos;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.push) begin
			valid_q <= sel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			value_q <= sel_value;
			pos_q   <= sel_pos;
		end
	end

	assign cur_valid = valid_q;
	assign cur_value = value_q;

endmodule

/* hdl/swmm_queue.sv */
// ---------------------------------------------------------------------------
// swmm_queue
// Monotonic queue built as a row of cells, front at cell 0. Handles the
// back pops, the append, the drop on overflow and the front retirement.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module swmm_queue #(
	parameter swmm_pkg::queue_kind_t KIND = swmm_pkg::QUEUE_MAX,
	parameter int N  = 64,
	parameter int SW = 32,
	parameter int PW = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 clear,
	input  logic                 retire,
	input  logic signed [SW-1:0] sample,
	input  logic [PW-1:0]        pos,
	output logic                 front_valid,
	output logic signed [SW-1:0] front_value,
	output logic [PW-1:0]        front_pos
);

	logic                 a_v [N+2];
	logic signed [SW-1:0] a_d [N+2];
	logic [PW-1:0]        a_p [N+2];
	logic                 k   [N];
	logic                 cur_v [N];
	logic signed [SW-1:0] cur_d [N];
	logic                 full;
	swmm_pkg::cell_ctrl_t ctrl;

	assign full = k[N-1];

	assign a_v[N]   = full;
	assign a_d[N]   = sample;
	assign a_p[N]   = pos;
	assign a_v[N+1] = 1'b0;
	assign a_d[N+1] = sample;
	assign a_p[N+1] = pos;

	always_comb begin
		ctrl.push  = push;
		ctrl.clear = clear;
		ctrl.shift = {full && retire, full ^ retire};
	end

	assign front_valid = full ? a_v[1] : a_v[0];
	assign front_value = full ? a_d[1] : a_d[0];
	assign front_pos   = full ? a_p[1] : a_p[0];

	for (genvar i = 0; i < N; i++) begin : g_cell
		swmm_cell #(
			.KIND (KIND),
			.SW   (SW),
			.PW   (PW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.sample     (sample),
			.pos        (pos),
			.prev_kept  ((i == 0) ? 1'b1 : k[(i == 0) ? 0 : i-1]),
			.nxt1_valid (a_v[i+1]),
			.nxt1_value (a_d[i+1]),
			.nxt1_pos   (a_p[i+1]),
			.nxt2_valid (a_v[i+2]),
			.nxt2_value (a_d[i+2]),
			.nxt2_pos   (a_p[i+2]),
			.kept       (k[i]),
			.a_valid    (a_v[i]),
			.a_value    (a_d[i]),
			.a_pos      (a_p[i]),
			.cur_valid  (cur_v[i]),
			.cur_value  (cur_d[i])
		);
	end

	for (genvar i = 1; i < N; i++) begin : g_chk
		`ASSERT_PROP(a_prefix, clk, arst_n, cur_v[i] |-> cur_v[i-1])
		if (KIND == swmm_pkg::QUEUE_MAX) begin : g_dec
			`ASSERT_PROP(a_order, clk, arst_n, cur_v[i] |-> (cur_d[i-1] > cur_d[i]))
		end else begin : g_inc
			`ASSERT_PROP(a_order, clk, arst_n, cur_v[i] |-> (cur_d[i-1] < cur_d[i]))
		end
	end

endmodule

/* hdl/swmm_outbuf.sv */
// ---------------------------------------------------------------------------
// swmm_outbuf
// Two-entry result buffer that decouples the output handshake from the input.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module swmm_outbuf #(
	parameter int W = 65
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         room,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	logic [1:0]   cnt_q;
	logic [W-1:0] d0_q;
	logic [W-1:0] d1_q;
	logic         pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign room      = (cnt_q != 2'd2);
	assign out_data  = d0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			d0_q <= (push && cnt_q == 2'd1) ? push_data : d1_q;
			if (push && cnt_q == 2'd2) begin
				d1_q <= push_data;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				d0_q <= push_data;
			end else begin
				d1_q <= push_data;
			end
		end
	end

	`ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q == 2'd3)

endmodule

/* dv/sliding_window_min_max_top_tb.sv */
// ---------------------------------------------------------------------------
// sliding_window_min_max_top_tb
// Drives signed sample sequences and window size writes into the sliding
// window min/max block and checks every result beat against a predictor
// built on a pair of monotonic queues. Directed cases come first, then
// random sequences under three pacing modes on both channels.
// ---------------------------------------------------------------------------
module sliding_window_min_max_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_W     = 32;
	localparam int WINDOW_MAX   = 64;
	localparam int POS_W        = 7;
	localparam int ITEM_TARGET  = 900;
	localparam int DRAIN_CYCLES = 4;
	localparam int TAIL_CYCLES  = 10;
	localparam int QUIET_LIMIT  = 2000;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct {
		sample_t peak;
		sample_t trough;
		logic    closing;
	} window_extremes_t;

	class minmax_tracker;
		sample_t                    desc_values[$];
		logic [POS_W-1:0]           desc_slots[$];
		sample_t                    asc_values[$];
		logic [POS_W-1:0]           asc_slots[$];
		logic [POS_W-1:0]           next_slot;
		logic [POS_W-1:0]           oldest_slot;
		int                         filled;
		logic [swmm_pkg::CFG_W-1:0] window_reg;
		window_extremes_t           pending_extremes[$];
		int unsigned                mismatch_count;

		function new();
			window_reg = swmm_pkg::WINDOW_RESET;
			mismatch_count = 0;
			clear_sequence();
		endfunction

		function void clear_sequence();
			desc_values.delete();
			desc_slots.delete();
			asc_values.delete();
			asc_slots.delete();
			next_slot = '0;
			oldest_slot = '0;
			filled = 0;
		endfunction

		function void set_window(logic [swmm_pkg::CFG_W-1:0] w);
			window_reg = w;
		endfunction

		function int pending();
			return pending_extremes.size();
		endfunction

		function void take_sample(sample_t v, logic last);
			int w;
			window_extremes_t r;
			w = (window_reg == 0) ? 1 : (window_reg > WINDOW_MAX) ? WINDOW_MAX : int'(window_reg);
			while (desc_values.size() > 0 && desc_values[$] <= v) begin
				desc_values.delete(desc_values.size() - 1);
				desc_slots.delete(desc_slots.size() - 1);
			end
			if (desc_values.size() >= WINDOW_MAX) begin
				desc_values.delete(0);
				desc_slots.delete(0);
			end
			desc_values.insert(desc_values.size(), v);
			desc_slots.insert(desc_slots.size(), next_slot);
			while (asc_values.size() > 0 && asc_values[$] >= v) begin
				asc_values.delete(asc_values.size() - 1);
				asc_slots.delete(asc_slots.size() - 1);
			end
			if (asc_values.size() >= WINDOW_MAX) begin
				asc_values.delete(0);
				asc_slots.delete(0);
			end
			asc_values.insert(asc_values.size(), v);
			asc_slots.insert(asc_slots.size(), next_slot);
			next_slot = next_slot + 1'b1;
			if (filled < w)
				filled++;
			if (filled >= w) begin
				r.peak = desc_values[0];
				r.trough = asc_values[0];
				r.closing = last;
				pending_extremes.insert(pending_extremes.size(), r);
				if (desc_slots.size() > 0 && desc_slots[0] == oldest_slot) begin
					desc_values.delete(0);
					desc_slots.delete(0);
				end
				if (asc_slots.size() > 0 && asc_slots[0] == oldest_slot) begin
					asc_values.delete(0);
					asc_slots.delete(0);
				end
				oldest_slot = oldest_slot + 1'b1;
			end
			if (last)
				clear_sequence();
		endfunction

		function void match_result(sample_t got_max, sample_t got_min, logic got_last);
			window_extremes_t want;
			if (pending_extremes.size() == 0) begin
				$display("%0t: unexpected result beat, window_max %0d window_min %0d",
					$time, got_max, got_min);
				mismatch_count++;
				return;
			end
			want = pending_extremes[0];
			pending_extremes.delete(0);
			if (got_max !== want.peak) begin
				$display("%0t: window_max expected %0d actual %0d", $time, want.peak, got_max);
				mismatch_count++;
			end
			if (got_min !== want.trough) begin
				$display("%0t: window_min expected %0d actual %0d", $time, want.trough, got_min);
				mismatch_count++;
			end
			if (got_last !== want.closing) begin
				$display("%0t: final_result expected %0b actual %0b",
					$time, want.closing, got_last);
				mismatch_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   src_gap_pct;
	int   sink_stall_pct;
	int   quiet_cycles;
	sample_t walk_value;
	bit   seq_monotone;
	int   seq_trend;

	minmax_tracker tracker = new();

	swmm_sample_if #(.SAMPLE_WIDTH(SAMPLE_W)) sample_ch ();
	swmm_result_if #(.SAMPLE_WIDTH(SAMPLE_W)) result_ch ();
	swmm_cfg_if                               cfg_ch ();

	sliding_window_min_max_top #(
		.MAX_WINDOW(WINDOW_MAX),
		.SAMPLE_WIDTH(SAMPLE_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(sample_ch),
		.results(result_ch),
		.cfg(cfg_ch)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready)
				tracker.match_result(result_ch.window_max, result_ch.window_min,
					result_ch.final_result);
			if (sample_ch.valid && sample_ch.ready)
				tracker.take_sample(sample_ch.sample_value, sample_ch.sequence_end);
			if (cfg_ch.valid && cfg_ch.ready)
				tracker.set_window(cfg_ch.window_size);
			if ((result_ch.valid && result_ch.ready) || (sample_ch.valid && sample_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic sample_t next_sample();
		int pick;
		pick = $urandom_range(99);
		if (seq_monotone)
			walk_value = walk_value + seq_trend * int'($urandom_range(1, 1000));
		else if (pick < 35)
			walk_value = $urandom;
		else if (pick < 65)
			walk_value = $signed($urandom_range(8)) - 4;
		else if (pick < 75)
			case ($urandom_range(3))
				0: walk_value = 32'sh7fff_ffff;
				1: walk_value = 32'sh8000_0000;
				2: walk_value = '0;
				default: walk_value = -1;
			endcase
		else
			walk_value = walk_value + $signed($urandom_range(6)) - 3;
		return walk_value;
	endfunction

	task automatic send_sample(input sample_t v, input logic last);
		while ($urandom_range(99) < src_gap_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample_value <= v;
		sample_ch.sequence_end <= last;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	task automatic run_sequence(input int len, input bit closed);
		seq_monotone = ($urandom_range(3) == 0);
		seq_trend = $urandom_range(1) ? 1 : -1;
		for (int i = 0; i < len; i++)
			send_sample(next_sample(), closed && (i == len - 1));
	endtask

	// drop valid, let every pending beat come back, then let the pipeline settle
	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [swmm_pkg::CFG_W-1:0] w);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.window_size <= w;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_pacing(input int src_pct, input int sink_pct);
		src_gap_pct = src_pct;
		sink_stall_pct = sink_pct;
	endtask

	initial begin
		int sent;
		int eff;
		int n_seq;
		int len;
		int pick;
		logic [swmm_pkg::CFG_W-1:0] w;

		arst_n <= 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.sample_value <= '0;
		sample_ch.sequence_end <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.window_size <= swmm_pkg::WINDOW_RESET;
		walk_value = '0;
		seq_monotone = 1'b0;
		seq_trend = 1;
		set_pacing(21, 80);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window: extremes, then a sequence shorter than the window, then ties
		send_sample(32'sh7fff_ffff, 1'b0);
		send_sample(32'sh8000_0000, 1'b0);
		send_sample('0, 1'b0);
		send_sample(-1, 1'b0);
		send_sample(1, 1'b1);
		send_sample(5, 1'b0);
		send_sample(5, 1'b1);
		repeat (4) send_sample(7, 1'b0);
		send_sample(7, 1'b1);

		// zero acts as one
		write_window('0);
		send_sample(-5, 1'b0);
		send_sample(9, 1'b0);
		send_sample(-2, 1'b1);

		// all ones saturates to the deepest window
		write_window('1);
		send_sample(32'sh5555_5555, 1'b0);
		send_sample(32'shaaaa_aaaa, 1'b0);
		send_sample(3, 1'b1);

		// resize in the middle of a sequence: shrink, then grow
		write_window(4);
		send_sample(10, 1'b0);
		send_sample(-10, 1'b0);
		send_sample(20, 1'b0);
		send_sample(-20, 1'b0);
		write_window(2);
		send_sample(15, 1'b0);
		send_sample(-15, 1'b0);
		write_window(6);
		send_sample(30, 1'b0);
		send_sample(-30, 1'b1);

		sent = 0;
		while (sent < ITEM_TARGET) begin
			if (sent >= 2 * ITEM_TARGET / 3)
				set_pacing(0, 0);
			else if (sent >= ITEM_TARGET / 3)
				set_pacing(80, 21);
			pick = $urandom_range(99);
			if (pick < 30)
				w = $urandom_range(1, 4);
			else if (pick < 55)
				w = $urandom_range(5, 12);
			else if (pick < 63)
				w = '0;
			else if (pick < 69)
				w = WINDOW_MAX;
			else if (pick < 74)
				w = $urandom_range(WINDOW_MAX + 1, 127);
			else
				w = $urandom_range(1, 40);
			write_window(w);
			eff = (w == 0) ? 1 : (w > WINDOW_MAX) ? WINDOW_MAX : int'(w);
			n_seq = (eff > 16) ? 1 : $urandom_range(1, 4);
			for (int s = 0; s < n_seq; s++) begin
				if (eff > 1 && $urandom_range(4) == 0)
					len = $urandom_range(1, eff - 1);
				else
					len = eff + $urandom_range(0, (eff < 8) ? 12 : 8);
				run_sequence(len, (s < n_seq - 1) || ($urandom_range(4) != 0));
				sent += len;
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.mismatch_count == 0 && tracker.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
